// ===== rtl/rfcd_pkg.sv =====
package rfcd_pkg;

  localparam int FIFO_DEPTH = 32;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int FILL_W     = 5;
  localparam int SPEED_W    = 7;
  localparam int CMD_W      = 4;

  localparam logic [SPEED_W-1:0] SPEED_MAX   = 7'd100;
  localparam logic [SPEED_W-1:0] SPEED_RESET = 7'd50;
  localparam logic [7:0]         CTRL_LIMIT  = 8'd32;

  localparam logic [CMD_W-1:0] OP_NOP      = 4'd0;
  localparam logic [CMD_W-1:0] OP_SPEED    = 4'd1;
  localparam logic [CMD_W-1:0] OP_FWD      = 4'd2;
  localparam logic [CMD_W-1:0] OP_BACK     = 4'd3;
  localparam logic [CMD_W-1:0] OP_TURN_L   = 4'd4;
  localparam logic [CMD_W-1:0] OP_TURN_R   = 4'd5;
  localparam logic [CMD_W-1:0] OP_HALT     = 4'd6;
  localparam logic [CMD_W-1:0] OP_LAMP_ON  = 4'd7;
  localparam logic [CMD_W-1:0] OP_LAMP_OFF = 4'd8;
  localparam logic [CMD_W-1:0] OP_AUTO     = 4'd9;
  localparam logic [CMD_W-1:0] OP_TEMP     = 4'd10;
  localparam logic [CMD_W-1:0] OP_HUMID    = 4'd11;
  localparam logic [CMD_W-1:0] OP_DIST     = 4'd12;
  localparam logic [CMD_W-1:0] OP_INFO     = 4'd13;
  localparam logic [CMD_W-1:0] OP_BAD      = 4'd14;

  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  localparam logic [0:0] REG_DEFAULT_SPEED = 1'b0;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
  } rfcd_in_t;

  typedef struct packed {
    logic [CMD_W-1:0]   command;
    logic [SPEED_W-1:0] speed;
    logic [FILL_W-1:0]  fill_count;
    logic               dropped;
  } rfcd_out_t;

  // Bookkeeping of one beat after the FIFO stage; the popped byte travels beside it.
  typedef struct packed {
    logic              pop_hit;
    logic              dropped;
    logic [FILL_W-1:0] fill_count;
  } rfcd_stage_t;

  typedef struct packed {
    logic               load;
    logic [SPEED_W-1:0] speed;
  } rfcd_cfg_t;

  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic               set_speed;
    logic [SPEED_W-1:0] speed;
  } rfcd_dec_t;

  function automatic rfcd_dec_t decode_byte(input logic [7:0] raw);
    logic [7:0] b;
    rfcd_dec_t  d;
    b           = raw;
    d.cmd       = OP_NOP;
    d.set_speed = 1'b0;
    d.speed     = '0;
    if (b inside {["a":"z"]}) begin
      b = b - 8'd32;
    end
    if (b inside {["1":"9"]}) begin
      d.cmd       = OP_SPEED;
      d.set_speed = 1'b1;
      // For ASCII digits the low nibble is the digit value.
      d.speed     = SPEED_W'(b[3:0]) * 7'd10;
    end else begin
      case (b)
        "F", "W": d.cmd = OP_FWD;
        "B", "X": d.cmd = OP_BACK;
        "L", "A": d.cmd = OP_TURN_L;
        "R", "D": d.cmd = OP_TURN_R;
        "S", " ": d.cmd = OP_HALT;
        "O":      d.cmd = OP_LAMP_ON;
        "P":      d.cmd = OP_LAMP_OFF;
        "M":      d.cmd = OP_AUTO;
        "T":      d.cmd = OP_TEMP;
        "H":      d.cmd = OP_HUMID;
        "U":      d.cmd = OP_DIST;
        "I":      d.cmd = OP_INFO;
        default: begin
          d.cmd = (b < CTRL_LIMIT) ? OP_NOP : OP_BAD;
        end
      endcase
    end
    return d;
  endfunction

endpackage

// ===== rtl/rx_fifo_command_decoder_core.sv =====
// Receive byte FIFO with a one-byte command decoder on its read side.
// Input channel (in_valid / in_stall / in_beat): a beat with req_type push
// stores rx_byte unless the FIFO already holds FIFO_DEPTH-1 bytes, in which
// case the byte is discarded and the result shows dropped. A pop beat takes
// the oldest byte, folds lower case to upper case and decodes it; on an
// empty FIFO it gives no command and leaves everything as it was.
// Output channel (out_valid / out_stall / out_beat): exactly one result per
// input beat, in order, with the command, the speed after the beat and the
// fill count after the beat.
// The FIFO stage updates the pointers and reads the byte store at the
// accepting edge, and the decode stage then loads the result register from
// the FIFO stage. One beat is accepted every cycle while in_stall is low;
// the limit is the single write and single read port of the byte store.
// When the receiver stalls, the result register holds and the FIFO stage
// holds behind it; in_stall rises only while both stages are occupied.
// Reset (rst, synchronous) empties the FIFO and loads the speed and the
// default_speed register with 50. Writing default_speed over APB also loads
// the speed; only pwdata[6:0] is used, and values above 100 are clipped to 100.
module rx_fifo_command_decoder_core import rfcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  rfcd_in_t    in_beat,
  output logic        out_valid,
  input  logic        out_stall,
  output rfcd_out_t   out_beat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  rfcd_cfg_t   cfg;
  logic        s1_valid;
  logic        s1_stall;
  rfcd_stage_t s1_info;
  logic [7:0]  s1_byte;

  rfcd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rfcd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .s1_valid (s1_valid),
    .s1_stall (s1_stall),
    .s1_info  (s1_info),
    .s1_byte  (s1_byte)
  );

  rfcd_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_stall  (s1_stall),
    .s1_info   (s1_info),
    .s1_byte   (s1_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_beat  (out_beat)
  );

endmodule

// ===== rtl/rfcd_cfg.sv =====
module rfcd_cfg import rfcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output rfcd_cfg_t   cfg
);

  logic [SPEED_W-1:0] default_speed;
  logic [SPEED_W-1:0] wr_speed;
  logic               wr_en;

  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite && (paddr[2:2] == REG_DEFAULT_SPEED);
  // Values above full speed saturate.
  assign wr_speed = (pwdata[SPEED_W-1:0] > SPEED_MAX) ? SPEED_MAX : pwdata[SPEED_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      default_speed <= SPEED_RESET;
    end else if (wr_en) begin
      default_speed <= wr_speed;
    end
  end

  assign prdata    = (paddr[2:2] == REG_DEFAULT_SPEED) ? 32'(default_speed) : '0;
  assign cfg.load  = wr_en;
  assign cfg.speed = wr_speed;

endmodule

// ===== rtl/rfcd_fifo.sv =====
module rfcd_fifo import rfcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  rfcd_in_t    in_beat,
  output logic        s1_valid,
  input  logic        s1_stall,
  output rfcd_stage_t s1_info,
  output logic [7:0]  s1_byte
);

  logic [7:0]       mem [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [PTR_W-1:0] wr_inc;
  logic [PTR_W-1:0] rd_inc;
  logic [PTR_W:0]   fill;
  logic             accept;
  logic             full;
  logic             empty;
  logic             do_push;
  logic             do_pop;

  assign in_stall = s1_valid && s1_stall;
  assign accept   = in_valid && !in_stall;

  assign wr_inc = (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
  assign rd_inc = (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
  // One slot always stays free so that equal pointers mean empty.
  assign full   = (wr_inc == rd_ptr);
  assign empty  = (wr_ptr == rd_ptr);

  assign do_push = accept && (in_beat.req_type == REQ_PUSH) && !full;
  assign do_pop  = accept && (in_beat.req_type == REQ_POP) && !empty;

  assign wr_ptr_next = do_push ? wr_inc : wr_ptr;
  assign rd_ptr_next = do_pop ? rd_inc : rd_ptr;

  always_comb begin
    if (wr_ptr_next >= rd_ptr_next) begin
      fill = {1'b0, wr_ptr_next} - {1'b0, rd_ptr_next};
    end else begin
      fill = {1'b0, wr_ptr_next} + (PTR_W + 1)'(FIFO_DEPTH) - {1'b0, rd_ptr_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      s1_valid <= 1'b0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (!s1_stall) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= in_beat.rx_byte;
    end
    if (do_pop) begin
      s1_byte <= mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_info.pop_hit    <= (in_beat.req_type == REQ_POP) && !empty;
      s1_info.dropped    <= (in_beat.req_type == REQ_PUSH) && full;
      s1_info.fill_count <= FILL_W'(fill);
    end
  end

endmodule

// ===== rtl/rfcd_decode.sv =====
module rfcd_decode import rfcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  rfcd_cfg_t   cfg,
  input  logic        s1_valid,
  output logic        s1_stall,
  input  rfcd_stage_t s1_info,
  input  logic [7:0]  s1_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output rfcd_out_t   out_beat
);

  logic [SPEED_W-1:0] speed;
  logic [SPEED_W-1:0] speed_next;
  rfcd_dec_t          dec;
  logic               advance;

  assign s1_stall = out_valid && out_stall;
  assign advance  = s1_valid && !s1_stall;
  assign dec      = decode_byte(s1_byte);

  always_comb begin
    speed_next = speed;
    if (s1_info.pop_hit && dec.set_speed) begin
      speed_next = dec.speed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed     <= SPEED_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg.load) begin
        speed <= cfg.speed;
      end else if (advance) begin
        speed <= speed_next;
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_beat.command    <= s1_info.pop_hit ? dec.cmd : OP_NOP;
      out_beat.speed      <= speed_next;
      out_beat.fill_count <= s1_info.fill_count;
      out_beat.dropped    <= s1_info.dropped;
    end
  end

endmodule

// ===== rtl/rfcd_checker.sv =====
module rfcd_sva import rfcd_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      out_valid,
  input logic      out_stall,
  input rfcd_out_t out_beat
);

  // A stalled result beat stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_beat))
    else $error("result beat changed while stalled");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_beat.speed <= SPEED_MAX)
    else $error("speed above full scale");

  // A dropped byte is only possible on a push, which never carries a command.
  a_drop_no_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.dropped |-> out_beat.command == OP_NOP)
    else $error("dropped push reported a command");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.dropped |-> out_beat.fill_count == FILL_W'(FIFO_DEPTH - 1))
    else $error("byte dropped while FIFO not full");

  a_set_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_beat.command == OP_SPEED |->
      out_beat.speed >= 7'd10 && out_beat.speed <= 7'd90)
    else $error("set speed command with speed outside digit range");

endmodule

bind rx_fifo_command_decoder_core rfcd_sva u_rfcd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_beat  (out_beat)
);

// ===== dv/rfcd_checker.sv =====
`timescale 1ns / 100ps

module rfcd_checker import rfcd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  rfcd_in_t    in_beat,
  input  logic        out_valid,
  input  logic        out_stall,
  input  rfcd_out_t   out_beat,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);

  logic [7:0]         fifo_bytes [FIFO_DEPTH];
  int                 wr_ptr;
  int                 rd_ptr;
  int                 mismatches;
  logic [SPEED_W-1:0] cur_speed;
  rfcd_out_t          expected_results [$];

  // Decodes one popped byte; a speed digit also updates the speed setting.
  function automatic logic [CMD_W-1:0] decode_and_apply(input logic [7:0] raw);
    logic [7:0] b;
    b = raw;
    if (b >= "a" && b <= "z") begin
      b = b - ("a" - "A");
    end
    if (b >= "1" && b <= "9") begin
      cur_speed = SPEED_W'((b - "0") * 10);
      return OP_SPEED;
    end
    case (b)
      "F", "W": return OP_FWD;
      "B", "X": return OP_BACK;
      "L", "A": return OP_TURN_L;
      "R", "D": return OP_TURN_R;
      "S", " ": return OP_HALT;
      "O":      return OP_LAMP_ON;
      "P":      return OP_LAMP_OFF;
      "M":      return OP_AUTO;
      "T":      return OP_TEMP;
      "H":      return OP_HUMID;
      "U":      return OP_DIST;
      "I":      return OP_INFO;
      default:  return (b < CTRL_LIMIT) ? OP_NOP : OP_BAD;
    endcase
  endfunction

  function automatic rfcd_out_t predict_fifo_result(input rfcd_in_t beat);
    rfcd_out_t r;
    int        nxt;
    r         = '0;
    r.command = OP_NOP;
    if (beat.req_type == REQ_PUSH) begin
      nxt = (wr_ptr + 1) % FIFO_DEPTH;
      if (nxt != rd_ptr) begin
        fifo_bytes[wr_ptr] = beat.rx_byte;
        wr_ptr             = nxt;
      end else begin
        r.dropped = 1'b1;
      end
    end else if (wr_ptr != rd_ptr) begin
      r.command = decode_and_apply(fifo_bytes[rd_ptr]);
      rd_ptr    = (rd_ptr + 1) % FIFO_DEPTH;
    end
    r.speed      = cur_speed;
    r.fill_count = FILL_W'((wr_ptr + FIFO_DEPTH - rd_ptr) % FIFO_DEPTH);
    return r;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want_v,
                             input logic [7:0] got_v);
    if (got_v !== want_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : watch
    rfcd_out_t want;
    if (rst) begin
      wr_ptr    = 0;
      rd_ptr    = 0;
      cur_speed = SPEED_RESET;
      expected_results.delete();
    end else begin
      // A write of default_speed also reloads the live speed.
      if (psel && penable && pwrite && pready && paddr[2:2] == REG_DEFAULT_SPEED) begin
        cur_speed = (pwdata[SPEED_W-1:0] > SPEED_MAX) ? SPEED_MAX : pwdata[SPEED_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("result beat with nothing outstanding: %p", out_beat);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          check_field("command", 8'(want.command), 8'(out_beat.command));
          check_field("speed", 8'(want.speed), 8'(out_beat.speed));
          check_field("fill_count", 8'(want.fill_count), 8'(out_beat.fill_count));
          check_field("dropped", 8'(want.dropped), 8'(out_beat.dropped));
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(predict_fifo_result(in_beat));
      end
    end
    fail_count <= mismatches;
    pending    <= expected_results.size();
  end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
  import rfcd_pkg::*;

  localparam int N_PHASES        = 7;
  localparam int ITEMS_PER_PHASE = 54;
  localparam int TIMEOUT_NS      = 1_000_000;

  localparam logic [2:0] ADDR_DEFAULT_SPEED = {REG_DEFAULT_SPEED, 2'b00};
  localparam logic [2:0] ADDR_UNMAPPED      = 3'd4;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  rfcd_in_t    in_beat   = '0;
  logic        out_stall = 1'b0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic        in_stall;
  logic        out_valid;
  rfcd_out_t   out_beat;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;

  bit    rx_quiet   = 1'b0;
  int    stall_left = 0;
  string cmd_chars  = "FWBXLARDSOPMTHUI 0123456789";

  int         push_pct [N_PHASES] = '{55, 85, 20, 70, 40, 95, 50};
  logic [2:0] cfg_addr [N_PHASES] = '{ADDR_DEFAULT_SPEED, ADDR_DEFAULT_SPEED,
                                      ADDR_DEFAULT_SPEED, ADDR_UNMAPPED,
                                      ADDR_DEFAULT_SPEED, ADDR_DEFAULT_SPEED,
                                      ADDR_DEFAULT_SPEED};
  logic [31:0] cfg_data [N_PHASES] = '{32'd0, 32'd100, 32'd127, 32'd0,
                                       32'd0, 32'hFFFF_FF80, 32'd37};
  logic [7:0] odd_bytes [11] = '{"9", "0", "f", "z", " ", 8'h00, 8'h1F,
                                 8'h7F, 8'h80, 8'hFF, "1"};

  always #2 clk = ~clk;

  rx_fifo_command_decoder_core i_dut (.*);

  rfcd_checker i_checker (.*);

  // Mostly short idle stretches, now and then a long one.
  function automatic int burst_len();
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_rx_byte();
    logic [7:0] b;
    int         r;
    r = $urandom_range(0, 9);
    if (r < 5) begin
      b = cmd_chars[$urandom_range(0, cmd_chars.len() - 1)];
      if (b >= "A" && b <= "Z" && $urandom_range(0, 1) == 1) begin
        b = b + ("a" - "A");
      end
    end else if (r < 7) begin
      b = 8'($urandom_range(0, 255));
    end else if (r == 7) begin
      b = 8'($urandom_range(0, 31));
    end else if (r == 8) begin
      b = 8'($urandom_range(127, 255));
    end else begin
      b = 8'($urandom_range(32, 126));
    end
    return b;
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall) begin
      out_stall  <= 1'b0;
      stall_left <= $urandom_range(0, 6);
    end else if (!rx_quiet && $urandom_range(0, 2) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= burst_len() - 1;
    end
  end

  task automatic send_beat(input logic req, input logic [7:0] b, input int gap_pct);
    rfcd_in_t beat;
    beat.req_type = req;
    beat.rx_byte  = b;
    in_beat  <= beat;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat (burst_len()) @(posedge clk);
    end
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Holds the sender back until every predicted result has come out.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int          gap_pct;
    logic        req;
    logic [31:0] data;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_beat(REQ_POP, 8'h00, 30);
    foreach (odd_bytes[i]) begin
      send_beat(REQ_PUSH, odd_bytes[i], 30);
    end
    foreach (odd_bytes[i]) begin
      send_beat(REQ_POP, 8'($urandom_range(0, 255)), 30);
    end
    send_beat(REQ_POP, 8'hFF, 30);

    for (int p = 0; p < N_PHASES; p++) begin
      drain_results();
      data = (p == 3 || p == 4) ? $urandom() : cfg_data[p];
      apb_write(cfg_addr[p], data);
      rx_quiet <= (p == 2);
      gap_pct = (p == 2 || p == 5) ? 0 : 30;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        req = ($urandom_range(0, 99) < push_pct[p]) ? REQ_PUSH : REQ_POP;
        send_beat(req, pick_rx_byte(), gap_pct);
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule

// ===== rx_fifo_command_decoder_core.f =====
rtl/rfcd_pkg.sv
rtl/rfcd_cfg.sv
rtl/rfcd_fifo.sv
rtl/rfcd_decode.sv
rtl/rx_fifo_command_decoder_core.sv
rtl/rfcd_checker.sv
dv/rfcd_checker.sv
dv/tb.sv
